[hdl/assert_macros.svh]
// Assertion macros for the sliding window maximum top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/swm_pkg.sv]
// Package with types and defaults for the sliding window maximum block.
`default_nettype none

package swm_pkg;

  // Default storage depth and sample width
  localparam int MAX_WINDOW_DEF   = 256;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Width of the window size register
  localparam int WS_WIDTH = 9;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FRONT
  } swm_state_t;

  // Memory enables from the sequencer
  typedef struct packed {
    logic dq_we;
    logic dq_re;
    logic hist_we;
    logic hist_re;
  } swm_mem_en_t;

endpackage

`default_nettype wire

[hdl/sliding_window_maximum.sv]
// Sliding window maximum: top level with config register, memories and output register.
//
// Usage:
//   in_*   : one transaction carries a signed sample (in_tdata) and a start
//            flag (in_tuser) that opens a new sequence with this sample.
//   out_*  : one transaction per sample once the window is full, carrying the
//            maximum of the last window_size samples.
//   cfg_*  : cfg_wr_en writes window_size (0 acts as 1, values above
//            MAX_WINDOW saturate); write it only while the block is idle.
// Flow: one sample is in work at a time; after it is taken, the block pops
//   smaller deque entries from the back, each pop one read of the deque
//   memory, then pushes and logs the sample and, once the window is full,
//   loads the front into the output register in a last step. Pops average
//   at most one per sample.
// Reset: the deque and window counters clear and window_size returns to 1;
//   the memories are not cleared and need no clearing pass.
// Stall: a held result sits in the output register; the next sample is
//   taken meanwhile and waits in its last step until the register frees.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int DW          = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input stream
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [DW-1:0]       in_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  wire logic                in_tuser,   // [0] start_req
  // Result stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [DW-1:0]       out_tdata,  // [SAMPLE_WIDTH-1:0] window_max
  // Configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [WS_WIDTH-1:0] cfg_wr_data
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic [CW-1:0]           win_m1_r, win_m1_nxt;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_data_r;

  swm_mem_en_t             mem_en;
  logic [AW-1:0]           dq_waddr, dq_raddr, hist_waddr, hist_raddr;
  logic [SAMPLE_WIDTH-1:0] wdata, dq_rdata, hist_rdata, emit_data;
  logic                    emit;
  logic                    out_free;
  logic                    in_fire;

  assign out_free   = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'(out_data_r);

  // Window size minus one, clamped to 0 .. MAX_WINDOW-1
  always_comb begin
    if (cfg_wr_data == '0) begin
      win_m1_nxt = '0;
    end else if (32'(cfg_wr_data) > 32'(MAX_WINDOW)) begin
      win_m1_nxt = CW'(MAX_WINDOW - 1);
    end else begin
      win_m1_nxt = CW'(cfg_wr_data - WS_WIDTH'(1));
    end
  end

  // Hold the configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_m1_r <= '0;
    end else if (cfg_wr_en) begin
      win_m1_r <= win_m1_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  swm_ctrl #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .AW           (AW),
    .CW           (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_start   (in_tuser),
    .win_m1     (win_m1_r),
    .out_free   (out_free),
    .dq_rdata   (dq_rdata),
    .hist_rdata (hist_rdata),
    .mem_en     (mem_en),
    .dq_waddr   (dq_waddr),
    .dq_raddr   (dq_raddr),
    .hist_waddr (hist_waddr),
    .hist_raddr (hist_raddr),
    .wdata      (wdata),
    .emit       (emit),
    .emit_data  (emit_data)
  );

  // Deque storage
  swm_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW),
    .DW    (SAMPLE_WIDTH)
  ) u_deque_ram (
    .clk   (clk),
    .we    (mem_en.dq_we),
    .waddr (dq_waddr),
    .wdata (wdata),
    .re    (mem_en.dq_re),
    .raddr (dq_raddr),
    .rdata (dq_rdata)
  );

  // Sample history line
  swm_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW),
    .DW    (SAMPLE_WIDTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (mem_en.hist_we),
    .waddr (hist_waddr),
    .wdata (wdata),
    .re    (mem_en.hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // A result never overwrites one that is still waiting
  `SWM_ASSERT_IMP(a_emit_free, emit, (!out_valid_r || out_tready), "result overwrote held output")
  // A taken transaction closes the input until its work is done
  `SWM_ASSERT_NXT(a_one_in_flight, in_fire, !in_tready, "second transaction taken while busy")
  // The deque is written only after the back-pop loop, never on the accept edge
  `SWM_ASSERT_IMP(a_no_push_on_accept, in_fire, !mem_en.dq_we, "deque write on accept cycle")

endmodule

`default_nettype wire

[hdl/swm_ram.sv]
// Simple dual-port synchronous memory, one write and one registered read port.
`default_nettype none

module swm_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, output held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/swm_ctrl.sv]
// Sequencer: deque and history pointers, back-pop loop, push and front check.
`default_nettype none

module swm_ctrl
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int AW           = 8,
  parameter int CW           = 9
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                    in_start,
  input  wire logic [CW-1:0]           win_m1,
  input  wire logic                    out_free,
  input  wire logic [SAMPLE_WIDTH-1:0] dq_rdata,
  input  wire logic [SAMPLE_WIDTH-1:0] hist_rdata,
  output swm_mem_en_t                  mem_en,
  output logic [AW-1:0]                dq_waddr,
  output logic [AW-1:0]                dq_raddr,
  output logic [AW-1:0]                hist_waddr,
  output logic [AW-1:0]                hist_raddr,
  output logic [SAMPLE_WIDTH-1:0]      wdata,
  output logic                         emit,
  output logic [SAMPLE_WIDTH-1:0]      emit_data
);

  localparam int LW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WINDOW - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_WINDOW);

  swm_state_t state_r, state_nxt;

  logic [SAMPLE_WIDTH-1:0] smp_r, smp_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [AW-1:0]           last_r, last_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           hptr_r, hptr_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic                    dq_fwd_r, dq_fwd_nxt;
  logic                    hist_fwd_r, hist_fwd_nxt;

  logic [AW-1:0]           head_push;
  logic [AW-1:0]           push_slot;
  logic [AW-1:0]           leave_idx;
  logic [LW-1:0]           cur_x;
  logic [LW-1:0]           wm1_x;
  logic [LW-1:0]           leave_x;
  logic [SAMPLE_WIDTH-1:0] front;
  logic [SAMPLE_WIDTH-1:0] leaving;
  logic                    full;
  logic                    drop_back;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
    return (x == LAST_IDX) ? '0 : x + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
    return (x == '0) ? LAST_IDX : x - AW'(1);
  endfunction

  // Slot of the sample that leaves the window: hptr - (w - 1), wrapped
  assign cur_x     = LW'(hptr_r);
  assign wm1_x     = LW'(win_m1);
  assign leave_x   = (cur_x >= wm1_x) ? cur_x - wm1_x
                                      : cur_x + LW'(MAX_WINDOW) - wm1_x;
  assign leave_idx = AW'(leave_x);

  // Push geometry: drop the front when the deque is full
  assign full      = (count_r == FULL_CNT);
  assign push_slot = idx_inc(last_r);
  assign head_push = full ? idx_inc(head_r) : head_r;

  // Back entry strictly smaller than the new sample
  assign drop_back = (count_r != '0) && ($signed(dq_rdata) < $signed(smp_r));

  // Front and leaving values, bypassing the memory when just written
  assign front     = dq_fwd_r   ? smp_r : dq_rdata;
  assign leaving   = hist_fwd_r ? smp_r : hist_rdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign wdata     = smp_r;
  assign dq_waddr  = push_slot;
  assign hist_waddr = hptr_r;
  assign hist_raddr = leave_idx;
  assign emit_data = front;

  // State and pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      last_r  <= LAST_IDX;
      count_r <= '0;
      hptr_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
      hptr_r  <= hptr_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Payload and bypass flags
  always_ff @(posedge clk) begin
    smp_r      <= smp_nxt;
    dq_fwd_r   <= dq_fwd_nxt;
    hist_fwd_r <= hist_fwd_nxt;
  end

  // Next state, pointer updates and memory requests
  always_comb begin
    state_nxt    = state_r;
    smp_nxt      = smp_r;
    head_nxt     = head_r;
    last_nxt     = last_r;
    count_nxt    = count_r;
    hptr_nxt     = hptr_r;
    fill_nxt     = fill_r;
    dq_fwd_nxt   = dq_fwd_r;
    hist_fwd_nxt = hist_fwd_r;
    mem_en       = '0;
    dq_raddr     = last_r;
    emit         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // Take the transaction and fetch the back entry
        if (in_valid) begin
          smp_nxt       = in_sample;
          mem_en.dq_re  = 1'b1;
          dq_raddr      = last_r;
          state_nxt     = ST_POP;
          if (in_start) begin
            head_nxt  = '0;
            last_nxt  = LAST_IDX;
            count_nxt = '0;
            hptr_nxt  = '0;
            fill_nxt  = '0;
          end
        end
      end

      ST_POP: begin
        if (drop_back) begin
          // Drop the back entry and fetch the one before it
          count_nxt    = count_r - CW'(1);
          last_nxt     = idx_dec(last_r);
          mem_en.dq_re = 1'b1;
          dq_raddr     = idx_dec(last_r);
        end else begin
          // Push the sample, log it, fetch front and leaving sample
          mem_en.dq_we   = 1'b1;
          mem_en.hist_we = 1'b1;
          mem_en.dq_re   = 1'b1;
          mem_en.hist_re = 1'b1;
          dq_raddr       = head_push;
          head_nxt       = head_push;
          last_nxt       = push_slot;
          count_nxt      = full ? count_r : count_r + CW'(1);
          hptr_nxt       = idx_inc(hptr_r);
          dq_fwd_nxt     = (head_push == push_slot);
          hist_fwd_nxt   = (leave_idx == hptr_r);
          if (fill_r < win_m1) begin
            fill_nxt  = fill_r + CW'(1);
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FRONT;
          end
        end
      end

      ST_FRONT: begin
        // Emit the front; retire it if it is the sample leaving the window
        if (out_free) begin
          emit      = 1'b1;
          fill_nxt  = win_m1;
          state_nxt = ST_IDLE;
          if (leaving == front && count_r != '0) begin
            head_nxt  = idx_inc(head_r);
            count_nxt = count_r - CW'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[tb/sv/sliding_window_maximum_tb.sv]
// Self-checking testbench for the sliding window maximum block.
`timescale 1ns / 1ps

module sliding_window_maximum_tb
  import swm_pkg::*;
();

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int DEPTH        = MAX_WINDOW_DEF;
  localparam int DW           = ((SW + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 19;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic [WS_WIDTH-1:0] wsize_t;

  // Content shapes for a random sequence
  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EXTREME
  } shape_e;

  // Running-maximum predictor and store of expected maxima
  class swm_scoreboard;
    sample_t recent[DEPTH];
    sample_t cand[DEPTH];
    int unsigned cand_head;
    int unsigned cand_count;
    int unsigned recent_wr;
    int unsigned fill;
    wsize_t      win_reg;
    sample_t     pending_max[$];
    int          errors;
    int          samples_noted;
    int          maxima_checked;

    function new();
      win_reg = 1;
      cand_head = 0;
      cand_count = 0;
      recent_wr = 0;
      fill = 0;
      errors = 0;
      samples_noted = 0;
      maxima_checked = 0;
    endfunction

    function void set_window(wsize_t v);
      win_reg = v;
    endfunction

    // Advance the window by one accepted sample
    function void note_sample(sample_t s, bit st);
      int unsigned w;
      int unsigned cur;
      int unsigned leave_idx;
      sample_t front;
      w = win_reg;
      if (w == 0) w = 1;
      if (w > DEPTH) w = DEPTH;
      samples_noted++;
      if (st) begin
        cand_head = 0;
        cand_count = 0;
        recent_wr = 0;
        fill = 0;
      end
      // drop strictly smaller candidates from the back, keep equals
      while (cand_count > 0 && cand[(cand_head + cand_count - 1) % DEPTH] < s)
        cand_count--;
      if (cand_count >= DEPTH) begin
        cand_head = (cand_head + 1) % DEPTH;
        cand_count--;
      end
      cand[(cand_head + cand_count) % DEPTH] = s;
      cand_count++;
      cur = recent_wr;
      recent[cur] = s;
      recent_wr = (cur + 1) % DEPTH;
      if (fill + 1 < w) begin
        fill++;
        return;
      end
      front = cand[cand_head];
      pending_max.insert(pending_max.size(), front);
      // retire the front when its sample leaves the window
      leave_idx = (cur + DEPTH - (w - 1)) % DEPTH;
      if (cand_count > 0 && recent[leave_idx] == front) begin
        cand_head = (cand_head + 1) % DEPTH;
        cand_count--;
      end
      fill = w - 1;
    endfunction

    function void check_max(sample_t got);
      sample_t want;
      if (pending_max.size() == 0) begin
        errors++;
        $display("%0t: window max with none pending: expected nothing, actual %0d",
                 $time, got);
        return;
      end
      want = pending_max[0];
      pending_max.delete(0);
      maxima_checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: window max mismatch: expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic           clk         = 1'b0;
  logic           rst_n       = 1'b0;
  logic           in_tvalid   = 1'b0;
  logic           in_tready;
  logic [DW-1:0]  in_tdata    = '0;   // [SW-1:0] sample
  logic           in_tuser    = 1'b0; // [0] start_req
  logic           out_tvalid;
  logic           out_tready  = 1'b0;
  logic [DW-1:0]  out_tdata;          // [SW-1:0] window_max
  logic           cfg_wr_en   = 1'b0;
  wsize_t         cfg_wr_data = '0;

  swm_scoreboard sb = new();
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cfg_writes = 0;
  int phases = 0;

  sliding_window_maximum u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one sample, with a random gap first; returns at a falling edge
  task automatic push_sample(input sample_t s, input bit st);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DW'(s);
    in_tuser  <= st;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_sample(s, st);
    @(negedge clk);
  endtask

  // Stop offering and wait until the block has gone quiet
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_max.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_window(input wsize_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_window(v);
    cfg_writes++;
  endtask

  function automatic wsize_t pick_window();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return wsize_t'($urandom_range(1, 8));
    if (r < 85) return wsize_t'($urandom_range(9, 40));
    if (r < 95) return wsize_t'($urandom_range(41, DEPTH - 1));
    case ($urandom_range(0, 3))
      0: return wsize_t'(0);
      1: return wsize_t'(DEPTH);
      2: return '1;
      default: return wsize_t'($urandom_range(DEPTH + 1, (1 << WS_WIDTH) - 1));
    endcase
  endfunction

  function automatic sample_t next_sample(shape_e shape, sample_t prev);
    case (shape)
      SHAPE_NARROW:  return sample_t'(int'($urandom_range(0, 8)) - 4);
      SHAPE_RISING:  return prev + sample_t'($urandom_range(0, 300));
      SHAPE_FALLING: return prev - sample_t'($urandom_range(0, 300));
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return sample_t'(-32768);
          1: return sample_t'(32767);
          2: return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Result side: random stalls, one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) sb.check_max(sample_t'(out_tdata[SW-1:0]));
    end
  end

  // Stimulus
  initial begin
    int rand_items;
    int len;
    int eff;
    bit first_start;
    bit st;
    shape_e shape;
    sample_t prev;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // window at its reset value of one: every sample is its own maximum
    push_sample(sample_t'(32767), 1'b1);
    push_sample(sample_t'(-32768), 1'b0);
    push_sample(sample_t'(0), 1'b0);
    push_sample(sample_t'(-1), 1'b0);
    push_sample(sample_t'(1), 1'b0);
    // zero window acts as one
    drain_block();
    write_window(0);
    push_sample(sample_t'(16'h5555), 1'b0);
    push_sample(sample_t'(16'hAAAA), 1'b0);
    // equal values kept, extremes, then a sequence shorter than the window
    drain_block();
    write_window(3);
    push_sample(sample_t'(5), 1'b1);
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(2), 1'b0);
    push_sample(sample_t'(9), 1'b0);
    push_sample(sample_t'(-32768), 1'b0);
    push_sample(sample_t'(-32768), 1'b0);
    push_sample(sample_t'(7), 1'b0);
    push_sample(sample_t'(4), 1'b1);
    push_sample(sample_t'(4), 1'b0);
    // oversized windows saturate to the full depth
    drain_block();
    write_window('1);
    push_sample(sample_t'(1), 1'b1);
    push_sample(sample_t'(2), 1'b0);
    push_sample(sample_t'(3), 1'b0);
    drain_block();
    write_window(wsize_t'(DEPTH + 1));
    push_sample(sample_t'(-5), 1'b1);
    push_sample(sample_t'(-6), 1'b0);

    // fill the candidate store past its depth: falling run, then shrink the window
    drain_block();
    write_window(wsize_t'(DEPTH));
    prev = sample_t'(32767);
    push_sample(prev, 1'b1);
    repeat (59) begin
      prev = prev - sample_t'($urandom_range(0, 3));
      push_sample(prev, 1'b0);
    end
    drain_block();
    write_window(2);
    repeat (220) begin
      prev = prev - sample_t'($urandom_range(0, 3));
      push_sample(prev, 1'b0);
    end

    // random sequences over random window settings
    rand_items = 0;
    prev = '0;
    while (rand_items < RANDOM_ITEMS) begin
      drain_block();
      calm = (phases == 2) || ($urandom_range(0, 99) < 15);
      first_start = ($urandom_range(0, 3) != 0);
      if (phases == 1) begin
        write_window(1);
        hold_req = 1'b1;
        first_start = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        write_window(pick_window());
      end
      eff = (sb.win_reg == 0) ? 1 : ((sb.win_reg > DEPTH) ? DEPTH : int'(sb.win_reg));
      if (phases != 1 && $urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, eff);
        first_start = 1'b1;
      end else begin
        len = eff + $urandom_range(0, 2 * eff + 8);
      end
      if (len > 400) len = 400;
      if (phases == 2 && len < 150) len = 150;
      if (phases == 1) len = 80;
      shape = shape_e'($urandom_range(0, 4));
      for (int i = 0; i < len; i++) begin
        st = (i == 0) ? first_start : ($urandom_range(0, 99) < 3);
        if ($urandom_range(0, 15) == 0) shape = shape_e'($urandom_range(0, 4));
        prev = next_sample(shape, prev);
        push_sample(prev, st);
        rand_items++;
      end
      phases++;
    end

    // drain and report
    calm = 1'b1;
    drain_block();
    if (sb.pending_max.size() != 0) begin
      sb.errors++;
      $display("%0t: expected %0d more window max values, actual 0",
               $time, sb.pending_max.size());
    end
    $display("Run covered %0d samples and %0d checked maxima over %0d window writes,",
             sb.samples_noted, sb.maxima_checked, cfg_writes);
    $display("  %0d random phases, candidate store overflow and a long output hold-off.",
             phases);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/swm_pkg.sv
hdl/swm_ram.sv
hdl/swm_ctrl.sv
hdl/sliding_window_maximum.sv
tb/sv/sliding_window_maximum_tb.sv
